[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define G2U_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define G2U_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/g2u_pkg.sv]
// shared types, constants and utf-8 helpers of the gbk to utf-8 decoder
package g2u_pkg;

  // command codes of an input request
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_CAPACITY = 1'b0;
  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // byte constants
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_LAST   = 8'hFE;
  localparam logic [7:0] TRAIL_FIRST = 8'h40;
  localparam logic [7:0] TRAIL_SKIP  = 8'h41;
  localparam logic [7:0] TRAIL_GAP   = 8'h7F;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;

  // code point bounds for utf-8 length
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // one queued unit of work: optional code point, then optional terminator
  typedef struct packed {
    logic        term;
    logic        has_data;
    logic [15:0] cp;
  } g2u_entry_t;

  function automatic logic [1:0] utf8_len(input logic [15:0] cp);
    logic [1:0] n;
    if (cp < CP_ONE_LIMIT) begin
      n = 2'd1;
    end else if (cp < CP_TWO_LIMIT) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] n,
                                           input logic [1:0] k);
    logic [7:0] b;
    unique case (n)
      2'd1: begin
        b = cp[7:0];
      end
      2'd2: begin
        b = (k == 2'd0) ? (8'hC0 | {3'b000, cp[10:6]}) : (8'h80 | {2'b00, cp[5:0]});
      end
      default: begin
        if (k == 2'd0) begin
          b = 8'hE0 | {4'b0000, cp[15:12]};
        end else if (k == 2'd1) begin
          b = 8'h80 | {2'b00, cp[11:6]};
        end else begin
          b = 8'h80 | {2'b00, cp[5:0]};
        end
      end
    endcase
    return b;
  endfunction

endpackage

[hdl/g2u_ram.sv]
// generic simple dual-port ram with registered read
module g2u_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 23940,
  parameter int ADDR_W = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/g2u_fifo.sv]
// small queue of work entries between front and back
module g2u_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  g2u_pkg::g2u_entry_t         push_entry,
  input  logic                        pop,
  output g2u_pkg::g2u_entry_t         head,
  output logic                        empty,
  output logic [g2u_pkg::QCNT_W-1:0]  count
);
  import g2u_pkg::*;

  g2u_entry_t mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[hdl/g2u_front.sv]
// front: accepts requests, tracks the lead byte, looks up pairs and queues work
module g2u_front #(
  parameter int LEAD_COUNT = 126,
  parameter int TRAIL_COUNT = 190,
  parameter int LEAD_FIRST = 129,
  parameter int ADDR_W = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [7:0]                  in_text_byte,
  input  logic [6:0]                  in_table_lead,
  input  logic [7:0]                  in_table_trail,
  input  logic [15:0]                 in_table_value,
  output logic                        ram_we,
  output logic [ADDR_W-1:0]           ram_waddr,
  output logic [15:0]                 ram_wdata,
  output logic [ADDR_W-1:0]           ram_raddr,
  input  logic [15:0]                 ram_rdata,
  input  logic [g2u_pkg::QCNT_W-1:0]  q_count,
  output logic                        push,
  output g2u_pkg::g2u_entry_t         push_entry
);
  import g2u_pkg::*;

  localparam logic [7:0] LEAD_FIRST_B  = 8'(LEAD_FIRST);
  localparam logic [7:0] LEAD_COUNT_B  = 8'(LEAD_COUNT);
  localparam logic [7:0] TRAIL_COUNT_B = 8'(TRAIL_COUNT);
  localparam logic [15:0] TRAIL_COUNT_W = 16'(TRAIL_COUNT);

  logic        accept;
  logic        lead_pending_r, lead_pending_nxt;
  logic [7:0]  held_li_r, held_li_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_use_ram_r, s1_use_ram_nxt;
  g2u_entry_t  s1_entry_r, s1_entry_nxt;
  logic [7:0]  trail_ti;
  logic        trail_ok;
  logic        lead_ok;
  logic        load_ok;
  logic [15:0] rd_addr_full;
  logic [15:0] wr_addr_full;
  logic [QCNT_W:0] q_used;

  // reserve a queue slot for the entry in flight in the lookup stage
  assign q_used   = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_r};
  assign in_ready = (q_used < (QCNT_W + 1)'(Q_DEPTH));
  assign accept   = in_valid && in_ready;

  // table loads
  assign load_ok      = ({1'b0, in_table_lead} < LEAD_COUNT_B) &&
                        (in_table_trail < TRAIL_COUNT_B);
  assign wr_addr_full = 16'(in_table_lead) * TRAIL_COUNT_W + 16'(in_table_trail);
  assign ram_we       = accept && (in_command == CMD_LOAD) && load_ok;
  assign ram_waddr    = ADDR_W'(wr_addr_full);
  assign ram_wdata    = in_table_value;

  // trail folding and pair lookup address
  assign trail_ti     = (in_text_byte < TRAIL_GAP) ? in_text_byte - TRAIL_FIRST
                                                   : in_text_byte - TRAIL_SKIP;
  assign trail_ok     = (in_text_byte >= TRAIL_FIRST) && (in_text_byte != TRAIL_GAP) &&
                        (trail_ti < TRAIL_COUNT_B);
  assign lead_ok      = (held_li_r < LEAD_COUNT_B);
  assign rd_addr_full = 16'(held_li_r) * TRAIL_COUNT_W + 16'(trail_ti);
  assign ram_raddr    = ADDR_W'(rd_addr_full);

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    held_li_nxt      = held_li_r;
    s1_valid_nxt     = 1'b0;
    s1_use_ram_nxt   = 1'b0;
    s1_entry_nxt     = '0;
    if (accept && (in_command == CMD_TEXT)) begin
      if (lead_pending_r) begin
        lead_pending_nxt      = 1'b0;
        held_li_nxt           = '0;
        s1_valid_nxt          = 1'b1;
        s1_entry_nxt.has_data = 1'b1;
        s1_entry_nxt.cp       = {8'h00, CHAR_QMARK};
        priority if (in_text_byte == BYTE_ZERO) begin
          s1_entry_nxt.term = 1'b1;
        end else if (lead_ok && trail_ok) begin
          s1_use_ram_nxt = 1'b1;
        end else begin
          s1_entry_nxt.term = 1'b0;
        end
      end else begin
        priority if (in_text_byte == BYTE_ZERO) begin
          s1_valid_nxt      = 1'b1;
          s1_entry_nxt.term = 1'b1;
        end else if (in_text_byte < ASCII_LIMIT) begin
          s1_valid_nxt          = 1'b1;
          s1_entry_nxt.has_data = 1'b1;
          s1_entry_nxt.cp       = {8'h00, in_text_byte};
        end else if ((in_text_byte >= LEAD_FIRST_B) && (in_text_byte <= LEAD_LAST)) begin
          lead_pending_nxt = 1'b1;
          held_li_nxt      = in_text_byte - LEAD_FIRST_B;
        end else begin
          s1_valid_nxt          = 1'b1;
          s1_entry_nxt.has_data = 1'b1;
          s1_entry_nxt.cp       = {8'h00, CHAR_QMARK};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      held_li_r      <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      held_li_r      <= held_li_nxt;
      s1_valid_r     <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_use_ram_r <= s1_use_ram_nxt;
    s1_entry_r   <= s1_entry_nxt;
  end

  // lookup result lands here; an undefined pair reads as zero
  always_comb begin
    push_entry = s1_entry_r;
    if (s1_use_ram_r) begin
      push_entry.cp = (ram_rdata == 16'h0000) ? {8'h00, CHAR_QMARK} : ram_rdata;
    end
  end

  assign push = s1_valid_r;

endmodule

[hdl/g2u_back.sv]
// back: expands queued code points to utf-8, applies capacity, adds terminators
module g2u_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          capacity,
  input  g2u_pkg::g2u_entry_t  head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import g2u_pkg::*;

  logic [1:0]  step_r, step_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  nb;
  logic [1:0]  data_steps;
  logic [2:0]  total;
  logic        is_data;
  logic        last_step;
  logic        fits;
  logic        can_out;
  logic        advance;

  assign nb         = utf8_len(head.cp);
  assign data_steps = head.has_data ? nb : 2'd0;
  assign total      = {1'b0, data_steps} + {2'b00, head.term};
  assign is_data    = (step_r < data_steps);
  assign last_step  = ({1'b0, step_r} == (total - 3'd1));
  assign fits       = ({1'b0, wc_r} + 17'd1) < {1'b0, capacity};
  assign can_out    = !out_valid_r || out_ready;

  always_comb begin
    advance       = 1'b0;
    wc_nxt        = wc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (!empty) begin
      if (is_data) begin
        if (!fits) begin
          advance = 1'b1;
        end else if (can_out) begin
          advance       = 1'b1;
          wc_nxt        = wc_r + 16'd1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = utf8_byte(head.cp, nb, step_r);
          out_last_nxt  = 1'b0;
        end
      end else if (can_out) begin
        advance       = 1'b1;
        wc_nxt        = '0;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = BYTE_ZERO;
        out_last_nxt  = 1'b1;
      end
    end
    step_nxt = step_r;
    if (advance) begin
      step_nxt = last_step ? 2'd0 : step_r + 2'd1;
    end
  end

  assign pop = advance && last_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[hdl/gbk_to_utf8_stream_decoder.sv]
// top level of the gbk (cp936) to utf-8 stream decoder
// GBK to UTF-8 stream decoder. Requests come in one per cycle while in_ready is
// high: a load request (command 0) writes one code table entry, a text request
// (command 1) carries one GBK byte, and a zero byte ends the string. ASCII passes
// through, a lead byte is held and paired with the next byte, the pair is looked
// up in the code table and leaves as 1 to 3 UTF-8 bytes; undefined pairs and
// stray bytes leave as '?'. Data bytes stop once the count plus one reaches
// out_capacity (register 0, byte address 0, reset 256); every string ends with a
// zero byte flagged out_last. Timing: the front takes one request per cycle while
// the queue has room; a text request is pushed into the queue in the cycle after
// acceptance (the registered table read), then passes the queue and the back's
// output register before its first byte is offered on the result channel. The
// back handles one UTF-8 byte (shown or dropped at capacity) or terminator per
// cycle, holding shown bytes while out_ready is low; this byte-per-cycle output
// sets the sustained rate. Load requests produce nothing. The code table has no
// reset: every entry must be loaded before text that uses it.
module gbk_to_utf8_stream_decoder #(
  parameter int LEAD_COUNT = 126,
  parameter int TRAIL_COUNT = 190,
  parameter int LEAD_FIRST = 129
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [7:0]                          in_text_byte,
  input  logic [6:0]                          in_table_lead,
  input  logic [7:0]                          in_table_trail,
  input  logic [15:0]                         in_table_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [g2u_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [g2u_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [g2u_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import g2u_pkg::*;

  // code table geometry follows the lead and trail ranges
  localparam int TABLE_DEPTH = LEAD_COUNT * TRAIL_COUNT;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [15:0]       capacity_r, capacity_nxt;
  logic              cfg_hit;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;
  logic              q_push;
  g2u_entry_t        q_push_entry;
  logic              q_pop;
  g2u_entry_t        q_head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  // configuration: one register, word index in paddr[2], zero-wait access
  assign cfg_hit = (paddr[2] == CFG_IDX_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {16'h0000, capacity_r} : '0;

  always_comb begin
    capacity_nxt = capacity_r;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      capacity_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // front: classify bytes, hold the lead, drive table loads and lookups
  g2u_front #(
    .LEAD_COUNT (LEAD_COUNT),
    .TRAIL_COUNT(TRAIL_COUNT),
    .LEAD_FIRST (LEAD_FIRST),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_text_byte  (in_text_byte),
    .in_table_lead (in_table_lead),
    .in_table_trail(in_table_trail),
    .in_table_value(in_table_value),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .q_count       (q_count),
    .push          (q_push),
    .push_entry    (q_push_entry)
  );

  // code table, one write port for loads, one read port for pair lookups
  g2u_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // decouples the lookup pipeline from the byte-serial back end
  g2u_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_push_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  // back: utf-8 expansion, capacity limit, terminator, output register
  g2u_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

[hdl/g2u_checker.sv]
// port-level checks of the result channel, bound to the top level
`include "assert_macros.svh"

module g2u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  `G2U_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid, "out_valid dropped before acceptance")
  `G2U_ASSERT_NEXT(a_out_payload_holds, out_valid && !out_ready, $stable(out_byte) && $stable(out_last), "stalled result changed")
  `G2U_ASSERT_NOW(a_term_is_zero, out_valid && out_last, out_byte == 8'h00, "terminator byte not zero")
  `G2U_ASSERT_NOW(a_data_nonzero, out_valid && !out_last, out_byte != 8'h00, "zero data byte without last")

endmodule

bind gbk_to_utf8_stream_decoder g2u_checker u_g2u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .out_last (out_last)
);
